@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ hdl/ormg_pkg.sv @@
// ----------------------------------------------------------------------------
// ormg_pkg
// Types, constants and fixed point helpers of the rectification map generator.
// ----------------------------------------------------------------------------
package ormg_pkg;

  localparam int NCOEF = 19;

  localparam int K_XI   = 9;
  localparam int K_K1   = 10;
  localparam int K_K2   = 11;
  localparam int K_P1   = 12;
  localparam int K_P2   = 13;
  localparam int K_FX   = 14;
  localparam int K_FY   = 15;
  localparam int K_CX   = 16;
  localparam int K_CY   = 17;
  localparam int K_SKEW = 18;

  typedef logic signed [63:0] fx_t;

  localparam logic [63:0] VMAX_U   = 64'h2000_0000_0000_0000;
  localparam fx_t         VMAX     = 64'sh2000_0000_0000_0000;
  localparam fx_t         VMIN     = -64'sh2000_0000_0000_0000;
  localparam fx_t         ONE_Q32  = 64'sh0000_0001_0000_0000;
  localparam fx_t         OUT_HALF = 64'sh0000_0000_0400_0000;
  localparam fx_t         OUT_MAX  = 64'sd131071;
  localparam fx_t         OUT_MIN  = -64'sd131072;

  typedef enum logic [1:0] {
    ST_VALID  = 2'd0,
    ST_BEHIND = 2'd1,
    ST_SAT    = 2'd2
  } status_t;

  typedef struct packed {
    logic [63:0] hh;
    logic [63:0] hl;
    logic [63:0] lh;
    logic [63:0] ll;
    logic        neg;
  } pp_t;

  typedef struct packed {
    fx_t  val;
    logic sat;
  } res_t;

  typedef struct packed {
    logic [2:0][47:0] kc;
    logic [9:0][47:0] kt;
    logic [5:0][63:0] prod;
    logic [2:0]       rneg;
    logic [2:0][62:0] mg;
    logic [62:0]      mx;
    logic             zero;
    logic [7:0]       grp_nz;
    logic [7:0][2:0]  grp_pos;
    logic [5:0]       pos;
    logic [2:0][29:0] ms;
    logic [2:0][59:0] sq;
    logic [62:0]      rt_rem;
    logic [30:0]      root;
    logic [2:0][32:0] dv_rem;
    logic [2:0][30:0] dv_q;
    logic [1:0][30:0] pmag;
    logic [1:0]       pneg;
    logic [47:0]      den;
    logic             behind;
    logic [1:0][48:0] pd_rem;
    logic [1:0][63:0] pd_q;
    fx_t xu, yu, k12x2, k13x2, xx, yy, xy, r2, xx2, yy2, r4, t1, tx, ty;
    fx_t t2, a1, px, py, qx, qy, g, gx, gy, xd1, yd1, xd, yd;
    fx_t fxd, syd, fyd, u1, v, u;
    pp_t pp_xx, pp_yy, pp_xy, pp_r4, pp_t1, pp_t2, pp_px, pp_py;
    pp_t pp_qx, pp_qy, pp_gx, pp_gy, pp_fxd, pp_syd, pp_fyd;
    logic             sat;
    logic [17:0]      ox;
    logic [17:0]      oy;
    status_t          ost;
  } work_t;

  function automatic fx_t sx48(input logic [47:0] k);
    return {{16{k[47]}}, k};
  endfunction

  function automatic logic [63:0] mag64(input fx_t a);
    logic [63:0] m;
    m = a[63] ? 64'(-a) : 64'(a);
    return m;
  endfunction

  function automatic pp_t smul_pp(input fx_t a, input fx_t b);
    logic [63:0] ua;
    logic [63:0] ub;
    pp_t p;
    ua = mag64(a);
    ub = mag64(b);
    p.hh  = ua[63:32] * ub[63:32];
    p.hl  = ua[63:32] * ub[31:0];
    p.lh  = ua[31:0] * ub[63:32];
    p.ll  = ua[31:0] * ub[31:0];
    p.neg = a[63] ^ b[63];
    return p;
  endfunction

  function automatic res_t smul_fin(input pp_t p);
    logic [63:0] r;
    res_t o;
    o.sat = 1'b0;
    if (p.hh >= 64'h2000_0000) begin
      r = VMAX_U;
      o.sat = 1'b1;
    end else begin
      r = (p.hh << 32) + p.hl + p.lh + (p.ll >> 32);
    end
    if (r > VMAX_U) begin
      r = VMAX_U;
      o.sat = 1'b1;
    end
    o.val = p.neg ? -$signed(r) : $signed(r);
    return o;
  endfunction

  function automatic res_t sadd(input fx_t a, input fx_t b);
    fx_t s;
    res_t o;
    s = a + b;
    o.sat = 1'b0;
    if (s > VMAX) begin
      s = VMAX;
      o.sat = 1'b1;
    end else if (s < VMIN) begin
      s = VMIN;
      o.sat = 1'b1;
    end
    o.val = s;
    return o;
  endfunction

endpackage

@@ hdl/omnidir_rectify_map_generator.sv @@
// ----------------------------------------------------------------------------
// omnidir_rectify_map_generator
// Maps rectified pixels to distorted source coordinates with the unified
// omnidirectional camera model, one pixel per clock while the output is not stalled, through a deep pipeline.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in_      slave      in_tvalid/in_tready    tdata index,value,row,col; tuser action
//  out_     master     out_tvalid/out_tready  tdata source_x,source_y; tuser status
//
// One request is taken per clock while in_tready is high; a map request passes
// through 31 square root stages, 31 ray divide stages and 64 projection divide
// stages plus the multiply and add stages around them.
// A coefficient write is registered and is seen by the next map request.
// Reset clears the coefficient store and all valid bits.
// A full stage holds while the stage after it holds, so empty slots close up.
module omnidir_rectify_map_generator
  import ormg_pkg::*;
#(
  parameter int PIXEL_COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // coef_index[4:0], coef_value[52:5], pixel_row[64:53],
                                  // pixel_col[76:65], zero fill
  input  logic        in_tuser,   // action[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // source_x[17:0], source_y[35:18], zero fill
  output logic [1:0]  out_tuser   // map_status[1:0]
);

  localparam int IDX_LSB = 0;
  localparam int VAL_LSB = 5;
  localparam int ROW_LSB = 53;
  localparam int COL_LSB = 65;
  localparam int PIX_BITS = (PIXEL_COORD_BITS < 12) ? PIXEL_COORD_BITS : 12;

  localparam int ROOT_STEPS = 31;
  localparam int DIV_STEPS  = 31;
  localparam int PDIV_STEPS = 64;

  localparam int S_PROD = 0;
  localparam int S_RAY  = 1;
  localparam int S_MAX  = 2;
  localparam int S_GRP  = 3;
  localparam int S_POS  = 4;
  localparam int S_SHF  = 5;
  localparam int S_SQ   = 6;
  localparam int S_SUM  = 7;
  localparam int S_RT   = 8;
  localparam int S_DV   = S_RT + ROOT_STEPS;
  localparam int S_DEN  = S_DV + DIV_STEPS;
  localparam int S_PD   = S_DEN + 1;
  localparam int S_RND  = S_PD + PDIV_STEPS;
  localparam int S_P1A  = S_RND + 1;
  localparam int S_P1B  = S_P1A + 1;
  localparam int S_P2   = S_P1B + 1;
  localparam int S_P3A  = S_P2 + 1;
  localparam int S_P3B  = S_P3A + 1;
  localparam int S_P4A  = S_P3B + 1;
  localparam int S_P4B  = S_P4A + 1;
  localparam int S_P5   = S_P4B + 1;
  localparam int S_P6A  = S_P5 + 1;
  localparam int S_P6B  = S_P6A + 1;
  localparam int S_P7   = S_P6B + 1;
  localparam int S_P8   = S_P7 + 1;
  localparam int S_P9A  = S_P8 + 1;
  localparam int S_P9B  = S_P9A + 1;
  localparam int S_P10  = S_P9B + 1;
  localparam int S_P11  = S_P10 + 1;
  localparam int S_OUT  = S_P11 + 1;
  localparam int NST    = S_OUT + 1;

  logic signed [47:0] coef_r [NCOEF];
  logic [NST-1:0]     vld_r;
  logic [NST-1:0]     vld_in;
  logic [NST-1:0]     en;
  work_t              pipe_r   [NST];
  work_t              pipe_nxt [NST];

  logic       map_req;
  logic       wr_req;
  logic [4:0] wr_idx;

  assign map_req   = in_tvalid && in_tuser;
  assign wr_req    = in_tvalid && in_tready && !in_tuser;
  assign wr_idx    = in_tdata[IDX_LSB +: 5];
  assign in_tready = en[0];
  assign vld_in    = {vld_r[NST-2:0], map_req};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (wr_req && (wr_idx < 5'(NCOEF))) begin
      coef_r[wr_idx] <= in_tdata[VAL_LSB +: 48];
    end
  end

  genvar gs;
  generate
    for (gs = 0; gs < NST; gs++) begin : g_stage
      if (gs == NST - 1) begin : g_last
        assign en[gs] = !vld_r[gs] || out_tready;
      end else begin : g_mid
        assign en[gs] = !vld_r[gs] || en[gs + 1];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[gs] <= 1'b0;
        end else if (en[gs]) begin
          vld_r[gs] <= vld_in[gs];
        end
      end

      always_ff @(posedge clk) begin
        if (en[gs]) begin
          pipe_r[gs] <= pipe_nxt[gs];
        end
      end

      if (gs == S_PROD) begin : g_in
        always_comb begin
          work_t             w;
          logic signed [14:0] cs;
          logic signed [14:0] rs;
          w  = '0;
          cs = {1'b0, 14'(in_tdata[COL_LSB +: PIX_BITS])};
          rs = {1'b0, 14'(in_tdata[ROW_LSB +: PIX_BITS])};
          for (int i = 0; i < 3; i++) begin
            w.prod[2*i]   = 64'(coef_r[3*i] * cs);
            w.prod[2*i+1] = 64'(coef_r[3*i+1] * rs);
            w.kc[i]       = coef_r[3*i+2];
          end
          for (int j = 0; j < 10; j++) begin
            w.kt[j] = coef_r[K_XI + j];
          end
          pipe_nxt[gs] = w;
        end
      end else begin : g_op
        always_comb begin
          work_t              w;
          res_t               t;
          fx_t                rv;
          logic [63:0]        mx64;
          logic [63:0]        d64;
          logic [63:0]        r64;
          logic [63:0]        q64;
          logic [32:0]        dr;
          logic [32:0]        rin;
          logic [48:0]        pr;
          logic [48:0]        pin;
          logic               bitv;
          logic               qsat;
          logic signed [31:0] zs;
          logic signed [49:0] zs_e;
          logic signed [49:0] k9_e;
          logic signed [49:0] den_s;
          fx_t                su;
          fx_t                sv;
          int                 k;
          int                 bi;
          w = pipe_r[gs - 1];
          if (gs == S_RAY) begin
            for (int l = 0; l < 3; l++) begin
              rv = $signed(w.prod[2*l]) + $signed(w.prod[2*l+1]) + sx48(w.kc[l]);
              w.rneg[l] = rv[63];
              w.mg[l]   = 63'(mag64(rv));
            end
          end else if (gs == S_MAX) begin
            w.mx = w.mg[0];
            if (w.mg[1] > w.mx) w.mx = w.mg[1];
            if (w.mg[2] > w.mx) w.mx = w.mg[2];
            w.zero = (w.mx == '0);
          end else if (gs == S_GRP) begin
            mx64 = {1'b0, w.mx};
            for (int g = 0; g < 8; g++) begin
              w.grp_nz[g]  = |mx64[8*g +: 8];
              w.grp_pos[g] = '0;
              for (int b = 0; b < 8; b++) begin
                if (mx64[8*g + b]) w.grp_pos[g] = 3'(b);
              end
            end
          end else if (gs == S_POS) begin
            w.pos = '0;
            for (int g = 0; g < 8; g++) begin
              if (w.grp_nz[g]) w.pos = {3'(g), w.grp_pos[g]};
            end
          end else if (gs == S_SHF) begin
            for (int l = 0; l < 3; l++) begin
              if (w.pos >= 6'd30) begin
                w.ms[l] = 30'(w.mg[l] >> (w.pos - 6'd29));
              end else begin
                w.ms[l] = 30'(w.mg[l] << (6'd29 - w.pos));
              end
            end
          end else if (gs == S_SQ) begin
            for (int l = 0; l < 3; l++) begin
              w.sq[l] = w.ms[l] * w.ms[l];
            end
          end else if (gs == S_SUM) begin
            w.rt_rem = 63'(w.sq[0]) + 63'(w.sq[1]) + 63'(w.sq[2]);
            w.root   = '0;
          end else if (gs >= S_RT && gs < S_DV) begin
            k   = gs - S_RT;
            bi  = ROOT_STEPS - 1 - k;
            d64 = (64'(w.root) << (bi + 1)) + (64'd1 << (2 * bi));
            if ({1'b0, w.rt_rem} >= d64) begin
              w.rt_rem   = w.rt_rem - d64[62:0];
              w.root[bi] = 1'b1;
            end
          end else if (gs >= S_DV && gs < S_DEN) begin
            k  = gs - S_DV;
            bi = DIV_STEPS - 1 - k;
            for (int l = 0; l < 3; l++) begin
              rin  = (k == 0) ? 33'(w.ms[l] >> 1) : w.dv_rem[l];
              bitv = (bi == DIV_STEPS - 1) ? w.ms[l][0] : 1'b0;
              dr   = {rin[31:0], bitv};
              if (dr >= {2'b0, w.root}) begin
                dr = dr - {2'b0, w.root};
                w.dv_q[l][bi] = 1'b1;
              end
              w.dv_rem[l] = dr;
            end
          end else if (gs == S_DEN) begin
            for (int l = 0; l < 2; l++) begin
              w.pmag[l] = w.dv_q[l];
              w.pneg[l] = w.rneg[l] && (w.dv_q[l] != '0);
            end
            zs       = w.rneg[2] ? -{1'b0, w.dv_q[2]} : {1'b0, w.dv_q[2]};
            zs_e     = {{18{zs[31]}}, zs};
            k9_e     = {{2{w.kt[K_XI-K_XI][47]}}, w.kt[K_XI-K_XI]};
            den_s    = (zs_e <<< 2) + k9_e;
            w.behind = w.zero || den_s[49] || (den_s == '0);
            w.den    = den_s[47:0];
          end else if (gs >= S_PD && gs < S_RND) begin
            k  = gs - S_PD;
            bi = PDIV_STEPS - 1 - k;
            for (int l = 0; l < 2; l++) begin
              pin  = (k == 0) ? '0 : w.pd_rem[l];
              bitv = 1'b0;
              if (bi >= 33) bitv = w.pmag[l][(bi >= 33) ? bi - 33 : 0];
              pr = {pin[47:0], bitv};
              if (pr >= {1'b0, w.den}) begin
                pr = pr - {1'b0, w.den};
                w.pd_q[l][bi] = 1'b1;
              end
              w.pd_rem[l] = pr;
            end
          end else if (gs == S_RND) begin
            for (int l = 0; l < 2; l++) begin
              q64  = w.pd_q[l];
              qsat = (q64[63:61] != '0) || (q64[60] && (q64[59:0] != '0));
              r64  = {q64[62:0], 1'b0} +
                     64'({w.pd_rem[l], 1'b0} >= {2'b0, w.den});
              if (qsat) r64 = VMAX_U;
              if (r64 > VMAX_U) begin
                r64  = VMAX_U;
                qsat = 1'b1;
              end
              w.sat = w.sat | qsat;
              rv = w.pneg[l] ? -$signed(r64) : $signed(r64);
              if (l == 0) w.xu = rv;
              else w.yu = rv;
            end
          end else if (gs == S_P1A) begin
            w.pp_xx = smul_pp(w.xu, w.xu);
            w.pp_yy = smul_pp(w.yu, w.yu);
            w.pp_xy = smul_pp(w.xu, w.yu);
            t = sadd(sx48(w.kt[K_P1-K_XI]), sx48(w.kt[K_P1-K_XI]));
            w.k12x2 = t.val; w.sat = w.sat | t.sat;
            t = sadd(sx48(w.kt[K_P2-K_XI]), sx48(w.kt[K_P2-K_XI]));
            w.k13x2 = t.val; w.sat = w.sat | t.sat;
          end else if (gs == S_P1B) begin
            t = smul_fin(w.pp_xx); w.xx = t.val; w.sat = w.sat | t.sat;
            t = smul_fin(w.pp_yy); w.yy = t.val; w.sat = w.sat | t.sat;
            t = smul_fin(w.pp_xy); w.xy = t.val; w.sat = w.sat | t.sat;
          end else if (gs == S_P2) begin
            t = sadd(w.xx, w.yy); w.r2  = t.val; w.sat = w.sat | t.sat;
            t = sadd(w.xx, w.xx); w.xx2 = t.val; w.sat = w.sat | t.sat;
            t = sadd(w.yy, w.yy); w.yy2 = t.val; w.sat = w.sat | t.sat;
          end else if (gs == S_P3A) begin
            w.pp_r4 = smul_pp(w.r2, w.r2);
            w.pp_t1 = smul_pp(sx48(w.kt[K_K1-K_XI]), w.r2);
            t = sadd(w.r2, w.xx2); w.tx = t.val; w.sat = w.sat | t.sat;
            t = sadd(w.r2, w.yy2); w.ty = t.val; w.sat = w.sat | t.sat;
          end else if (gs == S_P3B) begin
            t = smul_fin(w.pp_r4); w.r4 = t.val; w.sat = w.sat | t.sat;
            t = smul_fin(w.pp_t1); w.t1 = t.val; w.sat = w.sat | t.sat;
          end else if (gs == S_P4A) begin
            w.pp_t2 = smul_pp(sx48(w.kt[K_K2-K_XI]), w.r4);
            w.pp_px = smul_pp(w.k12x2, w.xy);
            w.pp_py = smul_pp(w.k13x2, w.xy);
            w.pp_qx = smul_pp(sx48(w.kt[K_P2-K_XI]), w.tx);
            w.pp_qy = smul_pp(sx48(w.kt[K_P1-K_XI]), w.ty);
            t = sadd(ONE_Q32, w.t1); w.a1 = t.val; w.sat = w.sat | t.sat;
          end else if (gs == S_P4B) begin
            t = smul_fin(w.pp_t2); w.t2 = t.val; w.sat = w.sat | t.sat;
            t = smul_fin(w.pp_px); w.px = t.val; w.sat = w.sat | t.sat;
            t = smul_fin(w.pp_py); w.py = t.val; w.sat = w.sat | t.sat;
            t = smul_fin(w.pp_qx); w.qx = t.val; w.sat = w.sat | t.sat;
            t = smul_fin(w.pp_qy); w.qy = t.val; w.sat = w.sat | t.sat;
          end else if (gs == S_P5) begin
            t = sadd(w.a1, w.t2); w.g = t.val; w.sat = w.sat | t.sat;
          end else if (gs == S_P6A) begin
            w.pp_gx = smul_pp(w.g, w.xu);
            w.pp_gy = smul_pp(w.g, w.yu);
          end else if (gs == S_P6B) begin
            t = smul_fin(w.pp_gx); w.gx = t.val; w.sat = w.sat | t.sat;
            t = smul_fin(w.pp_gy); w.gy = t.val; w.sat = w.sat | t.sat;
          end else if (gs == S_P7) begin
            t = sadd(w.gx, w.px); w.xd1 = t.val; w.sat = w.sat | t.sat;
            t = sadd(w.gy, w.py); w.yd1 = t.val; w.sat = w.sat | t.sat;
          end else if (gs == S_P8) begin
            t = sadd(w.xd1, w.qx); w.xd = t.val; w.sat = w.sat | t.sat;
            t = sadd(w.yd1, w.qy); w.yd = t.val; w.sat = w.sat | t.sat;
          end else if (gs == S_P9A) begin
            w.pp_fxd = smul_pp(sx48(w.kt[K_FX-K_XI]), w.xd);
            w.pp_syd = smul_pp(sx48(w.kt[K_SKEW-K_XI]), w.yd);
            w.pp_fyd = smul_pp(sx48(w.kt[K_FY-K_XI]), w.yd);
          end else if (gs == S_P9B) begin
            t = smul_fin(w.pp_fxd); w.fxd = t.val; w.sat = w.sat | t.sat;
            t = smul_fin(w.pp_syd); w.syd = t.val; w.sat = w.sat | t.sat;
            t = smul_fin(w.pp_fyd); w.fyd = t.val; w.sat = w.sat | t.sat;
          end else if (gs == S_P10) begin
            t = sadd(w.fxd, w.syd); w.u1 = t.val; w.sat = w.sat | t.sat;
            t = sadd(w.fyd, sx48(w.kt[K_CY-K_XI])); w.v = t.val; w.sat = w.sat | t.sat;
          end else if (gs == S_P11) begin
            t = sadd(w.u1, sx48(w.kt[K_CX-K_XI])); w.u = t.val; w.sat = w.sat | t.sat;
          end else begin
            su = (w.u + OUT_HALF) >>> 27;
            sv = (w.v + OUT_HALF) >>> 27;
            if (su > OUT_MAX) begin su = OUT_MAX; w.sat = 1'b1; end
            if (su < OUT_MIN) begin su = OUT_MIN; w.sat = 1'b1; end
            if (sv > OUT_MAX) begin sv = OUT_MAX; w.sat = 1'b1; end
            if (sv < OUT_MIN) begin sv = OUT_MIN; w.sat = 1'b1; end
            if (w.behind) begin
              w.ox  = '0;
              w.oy  = '0;
              w.ost = ST_BEHIND;
            end else begin
              w.ox  = su[17:0];
              w.oy  = sv[17:0];
              w.ost = w.sat ? ST_SAT : ST_VALID;
            end
          end
          pipe_nxt[gs] = w;
        end
      end
    end
  endgenerate

  assign out_tvalid = vld_r[S_OUT];
  assign out_tdata  = {4'd0, pipe_r[S_OUT].oy, pipe_r[S_OUT].ox};
  assign out_tuser  = pipe_r[S_OUT].ost;

endmodule

@@ hdl/ormg_checker.sv @@
// ----------------------------------------------------------------------------
// ormg_checker
// Port level checks of the rectification map generator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ormg_checker
  import ormg_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `ASSERT_CLK_NORST(a_reset_empty, clk, (!rst_n) |=> (!out_tvalid), "result after reset")

  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "stalled result changed")

  `ASSERT_CLK(a_behind_zero, clk, rst_n, (out_tvalid && (out_tuser == ST_BEHIND)) |-> (out_tdata[35:0] == 36'd0), "ray behind center with nonzero coordinate")

  `ASSERT_CLK(a_pad_zero, clk, rst_n, out_tvalid |-> (out_tdata[39:36] == 4'd0), "fill bits not zero")

endmodule

bind omnidir_rectify_map_generator ormg_checker u_ormg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
